FILE: design/assert_macros.svh
// Assertion macros shared by the gate RTL.
// No dependencies; files that assert take this header by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: design/pbpg_pkg.sv
// Shared types and constants for the publish burst and period gate.
// No dependencies; the csr, gate and top-level files refer to it by scoped names.
`default_nettype none

package pbpg_pkg;

   localparam int BURST_LIMIT = 10;
   localparam int PTR_W       = (BURST_LIMIT > 1) ? $clog2(BURST_LIMIT) : 1;

   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 32;
   localparam int WINDOW_W = 16;
   localparam int SEQ_W    = 32;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_DISABLED = 2'd1,
      VERDICT_PERIOD   = 2'd2,
      VERDICT_BURST    = 2'd3
   } verdict_type;

   typedef enum logic [0:0] {
      CSR_STATUS_PERIOD = 1'b0,
      CSR_BURST_WINDOW  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] hb_period;
      logic [WINDOW_W-1:0] burst_window;
   } cfg_type;

endpackage

`default_nettype wire

FILE: design/pbpg_csr.sv
// Configuration registers of the publish gate: heartbeat period and burst window.
// Depends on pbpg_pkg.
`default_nettype none

module pbpg_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [0:0]          csr_index,
   input  wire logic [31:0]         csr_data,
   output pbpg_pkg::cfg_type        cfg
);

   pbpg_pkg::cfg_type cfg_ff;
   pbpg_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (pbpg_pkg::csr_index_type'(csr_index))
            pbpg_pkg::CSR_STATUS_PERIOD: begin
               cfg_in.hb_period = csr_data[pbpg_pkg::PERIOD_W-1:0];
            end
            pbpg_pkg::CSR_BURST_WINDOW: begin
               cfg_in.burst_window = csr_data[pbpg_pkg::WINDOW_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hb_period    <= '0;
         cfg_ff.burst_window <= pbpg_pkg::WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: design/pbpg_gate.sv
// Decision logic and limiter state: period check, ring of publish times, counters.
// Depends on pbpg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pbpg_gate (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic                          mode,
   input  wire logic [pbpg_pkg::TIME_W-1:0]   now_sec,
   input  wire pbpg_pkg::cfg_type             cfg,
   output logic                               publish,
   output pbpg_pkg::verdict_type              verdict,
   output logic [pbpg_pkg::SEQ_W-1:0]         sequence_number
);

   localparam logic [pbpg_pkg::PTR_W-1:0] LAST_SLOT =
      pbpg_pkg::PTR_W'(pbpg_pkg::BURST_LIMIT - 1);

   logic [pbpg_pkg::TIME_W-1:0] times_ff [pbpg_pkg::BURST_LIMIT];
   logic [pbpg_pkg::PTR_W-1:0]  ptr_ff;
   logic [pbpg_pkg::PTR_W-1:0]  ptr_in;
   logic [pbpg_pkg::TIME_W-1:0] last_hb_ff;
   logic [pbpg_pkg::SEQ_W-1:0]  seq_ff;
   logic [pbpg_pkg::SEQ_W-1:0]  seq_in;

   logic [pbpg_pkg::TIME_W-1:0] held;
   logic [pbpg_pkg::TIME_W-1:0] hb_age;
   logic [pbpg_pkg::TIME_W-1:0] slot_age;
   logic                        burst_hit;
   logic                        ok;

   assign held     = times_ff[ptr_ff];
   assign hb_age   = now_sec - last_hb_ff;
   assign slot_age = now_sec - held;
   assign burst_hit = (held != '0) &&
      (slot_age < {{(pbpg_pkg::TIME_W - pbpg_pkg::WINDOW_W){1'b0}},
                   cfg.burst_window});

   always_comb begin
      verdict = pbpg_pkg::VERDICT_OK;
      if (mode && (cfg.hb_period == '0)) begin
         verdict = pbpg_pkg::VERDICT_DISABLED;
      end else if (mode && (last_hb_ff != '0) && (hb_age < cfg.hb_period)) begin
         verdict = pbpg_pkg::VERDICT_PERIOD;
      end else if (burst_hit) begin
         verdict = pbpg_pkg::VERDICT_BURST;
      end
   end

   assign ok      = (verdict == pbpg_pkg::VERDICT_OK);
   assign publish = ok;
   assign seq_in  = ok ? (seq_ff + pbpg_pkg::SEQ_W'(1)) : seq_ff;
   assign ptr_in  = (ptr_ff == LAST_SLOT) ? '0 : (ptr_ff + pbpg_pkg::PTR_W'(1));
   assign sequence_number = seq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pbpg_pkg::BURST_LIMIT; i++) begin
            times_ff[i] <= '0;
         end
         ptr_ff     <= '0;
         last_hb_ff <= '0;
         seq_ff     <= '0;
      end else if (fire && ok) begin
         times_ff[ptr_ff] <= now_sec;
         ptr_ff           <= ptr_in;
         seq_ff           <= seq_in;
         if (mode) begin
            last_hb_ff <= now_sec;
         end
      end
   end

   `ASSERT_NEXT(a_seq_step, clock, reset, fire && ok, seq_ff == $past(seq_in))
   `ASSERT_NEXT(a_refuse_hold, clock, reset, fire && !ok, $stable(ptr_ff) && $stable(seq_ff))
   `ASSERT_IMPLY(a_ptr_range, clock, reset, 1'b1, ptr_ff <= LAST_SLOT)

endmodule

`default_nettype wire

FILE: design/publish_burst_and_period_gate_unit.sv
// Top level of the publish burst and period gate: request/result registers and handshake.
// Depends on pbpg_pkg, pbpg_csr, pbpg_gate and assert_macros.svh.
// Usage:
//   Request channel (req_*): a transaction carries a mode (0 forced event,
//   1 periodic heartbeat) and the current time in seconds. It is taken at a
//   clock edge with req_valid high and req_stall low.
//   Result channel (rsp_*): one result per request with the publish flag, the
//   verdict code and the sequence count after the request. The receiver
//   drives rsp_stall; a held result keeps its payload.
//   Config channel (csr_*): index 0 is the heartbeat period, index 1 the
//   burst window. csr_ready is always high; write only while idle.
// Path: a request taken into the request register is decided by the gate as it
//   moves into the result register, and then shows on rsp_*.
// Throughput: one transaction per cycle while the result is not stalled; the gate
//   decides from the request register and updates its state as the result loads.
// Reset: clears the ring of publish times, the ring pointer, the heartbeat
//   time, the sequence count and both pipeline valids; the period resets to
//   zero (heartbeats off) and the window to 60 seconds.
// Stall: a stalled result holds; the request register still fills, then
//   req_stall rises until the result is taken.
`default_nettype none
`include "assert_macros.svh"

module publish_burst_and_period_gate_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [pbpg_pkg::TIME_W-1:0]   req_now_sec,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_publish,
   output logic [1:0]                         rsp_verdict,
   output logic [pbpg_pkg::SEQ_W-1:0]         rsp_sequence_number,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [0:0]                    csr_index,
   input  wire logic [31:0]                   csr_data
);

   pbpg_pkg::cfg_type cfg;

   // Request register
   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic                        in_mode_ff;
   logic [pbpg_pkg::TIME_W-1:0] in_now_ff;

   // Result register
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_publish_ff;
   pbpg_pkg::verdict_type       rsp_verdict_ff;
   logic [pbpg_pkg::SEQ_W-1:0]  rsp_seq_ff;

   // Gate outputs for the request in the register
   logic                        gate_publish;
   pbpg_pkg::verdict_type       gate_verdict;
   logic [pbpg_pkg::SEQ_W-1:0]  gate_seq;

   logic                        take;
   logic                        move;

   pbpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Advance the held request when the result register is free or draining.
   assign move = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign take = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);

   pbpg_gate u_gate (
      .clock           (clock),
      .reset           (reset),
      .fire            (move),
      .mode            (in_mode_ff),
      .now_sec         (in_now_ff),
      .cfg             (cfg),
      .publish         (gate_publish),
      .verdict         (gate_verdict),
      .sequence_number (gate_seq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff <= req_mode;
         in_now_ff  <= req_now_sec;
      end
      if (move) begin
         rsp_publish_ff <= gate_publish;
         rsp_verdict_ff <= gate_verdict;
         rsp_seq_ff     <= gate_seq;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_publish         = rsp_publish_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_sequence_number = rsp_seq_ff;

   `ASSERT_NEXT(a_move_fills_rsp, clock, reset, move, rsp_valid_ff)
   `ASSERT_IMPLY(a_empty_no_stall, clock, reset, !in_valid_ff, !req_stall)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, $stable(rsp_seq_ff))

endmodule

`default_nettype wire
